// File: rtl/core/shws_pkg.sv
// ----------------------------------------------------------------------------
// shws_pkg: shared types and constants
// Sample entry type, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package shws_pkg;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 31;

	localparam logic [CFG_AW-1:0] REG_WINDOW_LEN   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_MOVE_THRESH  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MOVE_MAX_LEN = 2'd2;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 112;

	typedef struct packed {
		logic [31:0]        tm;
		logic signed [31:0] val;
	} entry_t;

	// magnitude of the difference of two Q16.16 values
	function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d[32] ? (33'd0 - d) : d;
	endfunction

endpackage

// File: rtl/core/shws_cell.sv
// ----------------------------------------------------------------------------
// shws_cell: one entry of the sample chain
// Takes the newer neighbor's entry on a store, the older neighbor's on a rotate.
// ----------------------------------------------------------------------------
module shws_cell (
	input  logic             clk,
	input  logic             load,
	input  logic             rot,
	input  shws_pkg::entry_t newer,
	input  shws_pkg::entry_t older,
	output shws_pkg::entry_t q
);
	import shws_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= newer;
		end else if (rot) begin
			ent_q <= older;
		end
	end

	assign q = ent_q;

endmodule

// File: rtl/core/shws_div.sv
// ----------------------------------------------------------------------------
// shws_div: restoring divider
// Unsigned quotient, one bit per cycle while busy; start is ignored while busy.
// ----------------------------------------------------------------------------
module shws_div #(
	parameter int NW = 68,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      part;
	logic             ge;

	always_comb begin
		part = {rem_q, quo_q[NW-1]};
		ge   = part >= {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? DW'(part - {1'b0, den}) : part[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/core/shws_sqrt.sv
// ----------------------------------------------------------------------------
// shws_sqrt: integer square root
// Floor square root of a 64-bit word, one result bit per cycle while busy.
// ----------------------------------------------------------------------------
module shws_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] part;
	logic [35:0] trial;
	logic        ge;

	always_comb begin
		part  = {rem_q, x_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		ge    = part >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(part - trial) : part[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/core/sample_history_window_statistics_core.sv
// ----------------------------------------------------------------------------
// sample_history_window_statistics_core: moving statistics over a sample chain
// Keeps the newest DEPTH samples and reports rate, mean, stddev, movement, fill.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one request (sample time, sample value). It is stored at
//   the head of a chain of DEPTH cells and one result leaves on m_tdata.
//   The chain then rotates through all DEPTH cells in each round, presenting
//   every entry at the head: round 0 gathers the sum, rate span end points and
//   the movement walk; each round also adds the squared differences of one
//   entry against every older entry in the window. Rounds = max(1, k-1),
//   k = window size. After that one shared divider runs three divisions
//   (mean, rate, variance) in turn, then a 32-step square root. One request
//   is worked at a time.
//   s_tready is high only while no request is at work. A result waiting on a
//   stalled m_tready does not block the next request; its result is held back
//   until the output register is free.
//   Reset empties the chain (fill 0) and loads the register defaults.
//   cfg_we/cfg_addr/cfg_data write a register. The user must write only
//   while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sample_history_window_statistics_core #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [shws_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [shws_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] sample_time, [63:32] sample_value
	input  logic [shws_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] rate_out, [63:32] mean_out, [94:64] stddev_out,
	// [99:95] movement_steps, [104:100] fill_out, [111:105] zero
	output logic [shws_pkg::M_TDATA_W-1:0]    m_tdata
);
	import shws_pkg::*;

	localparam int KW    = $clog2(DEPTH + 1);
	localparam int PW    = $clog2(DEPTH);
	localparam int XW    = ((KW > 5) ? KW : 5) + 1;
	localparam int SUM_W = 32 + KW;
	localparam int ACC_W = 66 + $clog2(DEPTH * DEPTH);
	localparam int DW    = (2 * KW > 33) ? 2 * KW : 33;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WALK = 4'd1;
	localparam logic [3:0] ST_DRN1 = 4'd2;
	localparam logic [3:0] ST_DRN2 = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_SQRT = 4'd5;
	localparam logic [3:0] ST_OUT  = 4'd6;

	localparam logic [1:0] DSEL_MEAN = 2'd0;
	localparam logic [1:0] DSEL_RATE = 2'd1;
	localparam logic [1:0] DSEL_VAR  = 2'd2;

	logic [3:0]  state_q;
	logic [4:0]  wl_q;
	logic [30:0] thr_q;
	logic [4:0]  max_q;
	logic [KW-1:0] fill_q;
	logic [PW-1:0] p_q;
	logic [KW-1:0] r_q;

	entry_t cells [DEPTH];
	entry_t newer [DEPTH];
	entry_t older [DEPTH];
	entry_t head;
	logic   accept;
	logic   rot;

	logic [KW-1:0] k_c;
	logic [KW-1:0] old_c;
	logic [KW-1:0] rounds_c;
	logic [2*KW-1:0] pairs_c;
	logic [XW-1:0] p_x;

	logic [31:0]        vn_q, tn_q, vo_q, to_q, vi_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ACC_W-1:0]   acc_q;
	logic [32:0]        d_s1;
	logic               v_s1;
	logic [65:0]        sq_s2;
	logic               v_s2;
	logic               mdone_q;
	logic [PW-1:0]      mv_q;

	logic [1:0]  dsel_q;
	logic        dgo_q;
	logic        div_start;
	logic [ACC_W-1:0] div_num;
	logic [DW-1:0]    div_den;
	logic        div_busy, div_done;
	logic [ACC_W-1:0] div_quo;
	logic [SUM_W-1:0] sum_mag;
	logic [32:0] dv_c, dt_c, dv_mag, dt_mag;
	logic        rate_neg;

	logic [31:0] mean_q, rate_q;
	logic        sd_sat_q, sd_zero_q;
	logic [63:0] var_q;
	logic        sq_start;
	logic        sq_done;
	logic [31:0] sq_root;
	logic [30:0] sd_q;

	logic        mvalid_q;
	logic [M_TDATA_W-1:0] mdata_q;

	assign accept = s_tvalid && s_tready;
	assign rot    = (state_q == ST_WALK);
	assign head   = cells[0];

	// chain of cells: stores push toward the tail, rotates pull toward the head
	for (genvar c = 0; c < DEPTH; c++) begin : g_cell
		if (c == 0) begin : g_head
			assign newer[c] = '{tm: s_tdata[31:0], val: s_tdata[63:32]};
		end else begin : g_body
			assign newer[c] = cells[c-1];
		end
		assign older[c] = cells[(c + 1) % DEPTH];
		shws_cell u_cell (
			.clk   (clk),
			.load  (accept),
			.rot   (rot),
			.newer (newer[c]),
			.older (older[c]),
			.q     (cells[c])
		);
	end

	always_comb begin
		k_c      = (XW'(wl_q) < XW'(fill_q)) ? KW'(wl_q) : fill_q;
		old_c    = (XW'(wl_q) >= XW'(fill_q)) ? (fill_q - 1'b1) : KW'(wl_q);
		rounds_c = (k_c >= KW'(2)) ? (k_c - 1'b1) : KW'(1);
		pairs_c  = (2*KW)'(k_c) * (2*KW)'(k_c - 1'b1);
		p_x      = XW'(p_q);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= 5'd16;
			thr_q <= '0;
			max_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WINDOW_LEN:   wl_q  <= cfg_data[4:0];
				REG_MOVE_THRESH:  thr_q <= cfg_data;
				REG_MOVE_MAX_LEN: max_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			p_q      <= '0;
			r_q      <= '0;
			dsel_q   <= DSEL_MEAN;
			dgo_q    <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!mvalid_q || m_tready)) begin
				mvalid_q <= 1'b1;
			end else if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						p_q     <= '0;
						r_q     <= '0;
						if (fill_q != KW'(DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_WALK: begin
					if (p_q == PW'(DEPTH - 1)) begin
						p_q <= '0;
						if (r_q == rounds_c - 1'b1) begin
							state_q <= ST_DRN1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_DRN1: state_q <= ST_DRN2;
				ST_DRN2: begin
					state_q <= ST_DIV;
					dsel_q  <= DSEL_MEAN;
					dgo_q   <= 1'b0;
				end
				ST_DIV: begin
					if (!dgo_q && !div_busy) begin
						dgo_q <= 1'b1;
					end else if (div_done) begin
						dgo_q <= 1'b0;
						if (dsel_q == DSEL_VAR) begin
							state_q <= ST_SQRT;
						end else begin
							dsel_q <= dsel_q + 1'b1;
						end
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!mvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// gather over the rotating chain
	always_ff @(posedge clk) begin
		v_s1 <= rot && p_x > XW'(r_q) && p_x < XW'(k_c);
		if (accept) begin
			sum_q   <= '0;
			acc_q   <= '0;
			mdone_q <= 1'b0;
			mv_q    <= '0;
		end else if (state_q == ST_WALK) begin
			if (r_q == '0) begin
				if (p_q == '0) begin
					vn_q <= head.val;
					tn_q <= head.tm;
				end
				if (XW'(p_q) == XW'(old_c)) begin
					vo_q <= head.val;
					to_q <= head.tm;
				end
				if (p_x < XW'(k_c)) begin
					sum_q <= sum_q + SUM_W'(head.val);
				end
				if (p_q != '0 && p_x < XW'(fill_q) && p_x <= XW'(max_q) && !mdone_q) begin
					mv_q <= p_q;
					if (abs_diff(vn_q, head.val) >= {2'b00, thr_q}) begin
						mdone_q <= 1'b1;
					end
				end
			end
			if (XW'(p_q) == XW'(r_q)) begin
				vi_q <= head.val;
			end
			if (p_x > XW'(r_q) && p_x < XW'(k_c)) begin
				d_s1 <= abs_diff(vi_q, head.val);
			end
		end
		v_s2  <= v_s1;
		sq_s2 <= 66'(d_s1) * 66'(d_s1);
		if (v_s2 && !accept) begin
			acc_q <= acc_q + ACC_W'(sq_s2);
		end
	end

	// divider operands
	always_comb begin
		sum_mag  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
		dv_c     = {vn_q[31], vn_q} - {vo_q[31], vo_q};
		dt_c     = {1'b0, tn_q} - {1'b0, to_q};
		dv_mag   = dv_c[32] ? (33'd0 - dv_c) : dv_c;
		dt_mag   = dt_c[32] ? (33'd0 - dt_c) : dt_c;
		rate_neg = dv_c[32] ^ dt_c[32];
		case (dsel_q)
			DSEL_MEAN: begin
				div_num = ACC_W'(sum_mag);
				div_den = DW'(k_c);
			end
			DSEL_RATE: begin
				div_num = ACC_W'(dv_mag);
				div_den = DW'(dt_mag);
			end
			DSEL_VAR: begin
				div_num = acc_q;
				div_den = DW'(pairs_c);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_DIV) && !dgo_q && !div_busy;

	shws_div #(.NW(ACC_W), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			case (dsel_q)
				DSEL_MEAN: begin
					if (k_c == '0) begin
						mean_q <= '0;
					end else if (sum_q[SUM_W-1]) begin
						mean_q <= 32'd0 - 32'(div_quo);
					end else begin
						mean_q <= 32'(div_quo);
					end
				end
				DSEL_RATE: begin
					if (fill_q < KW'(2) || dt_c == '0) begin
						rate_q <= '0;
					end else if (rate_neg) begin
						rate_q <= (div_quo > ACC_W'(33'h080000000)) ? 32'h80000000
							: 32'd0 - 32'(div_quo);
					end else begin
						rate_q <= (div_quo > ACC_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF
							: 32'(div_quo);
					end
				end
				DSEL_VAR: begin
					var_q     <= div_quo[63:0];
					sd_sat_q  <= div_quo[ACC_W-1:64] != '0;
					sd_zero_q <= k_c <= KW'(1);
				end
				default: ;
			endcase
		end
	end

	assign sq_start = (state_q == ST_SQRT) && !sq_done;

	shws_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (var_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_SQRT && sq_done) begin
			if (sd_zero_q) begin
				sd_q <= '0;
			end else if (sd_sat_q || sq_root[31]) begin
				sd_q <= 31'h7FFFFFFF;
			end else begin
				sd_q <= sq_root[30:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!mvalid_q || m_tready)) begin
			mdata_q <= {7'd0, 5'(fill_q), 5'(mv_q), sd_q, mean_q, rate_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

endmodule

// File: bench/sample_history_window_statistics_core_test.sv
// ----------------------------------------------------------------------------
// sample_history_window_statistics_core_test: self-checking stream bench
// Drives timestamped samples with random gaps and output stalls, predicts rate,
// mean, stddev, movement and fill for each request, and compares every result.
// ----------------------------------------------------------------------------
module sample_history_window_statistics_core_test;
	import shws_pkg::*;

	localparam int DEPTH = 16;
	localparam int SETTLE = 600;

	typedef struct packed {
		logic [31:0] tm;
		logic [31:0] val;
	} sample_t;

	typedef struct {
		logic [31:0] rate;
		logic [31:0] mean;
		logic [30:0] sdev;
		logic [4:0]  moves;
		logic [4:0]  fill;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	sample_history_window_statistics_core #(.DEPTH(DEPTH)) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] hist_val [DEPTH];
	logic [31:0] hist_tm [DEPTH];
	int unsigned head_slot;
	int unsigned held;
	int unsigned win_len, thresh, max_len;

	sample_t pending_samples[$];
	stats_t expected_stats[$];
	int errors = 0;
	bit pause_req = 1'b0;

	function automatic logic signed [63:0] val_back(int unsigned i);
		return 64'(signed'(hist_val[(head_slot + DEPTH - i) % DEPTH]));
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic stats_t window_stats(sample_t s);
		stats_t o;
		int unsigned k, old_i, n;
		logic signed [63:0] dv, dt, q, sum, df;
		logic [127:0] sq_sum, var_q;
		logic [63:0] a;
		head_slot = (head_slot + 1) % DEPTH;
		hist_tm[head_slot] = s.tm;
		hist_val[head_slot] = s.val;
		if (held < DEPTH) held++;
		o.rate = 0;
		if (held >= 2) begin
			old_i = (win_len >= held) ? held - 1 : win_len;
			dv = val_back(0) - val_back(old_i);
			dt = $signed({32'd0, hist_tm[head_slot]})
				- $signed({32'd0, hist_tm[(head_slot + DEPTH - old_i) % DEPTH]});
			if (dt != 0) begin
				q = dv / dt;
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				o.rate = q[31:0];
			end
		end
		k = (win_len < held) ? win_len : held;
		sum = 0;
		for (int i = 0; i < k; i++) sum += val_back(i);
		o.mean = (k == 0) ? 32'd0 : 32'(sum / $signed(64'(k)));
		o.sdev = 0;
		if (k > 1) begin
			sq_sum = 0;
			for (int i = 0; i < k; i++)
				for (int j = i + 1; j < k; j++) begin
					df = val_back(i) - val_back(j);
					a = df < 0 ? -df : df;
					sq_sum += 128'(a) * 128'(a);
				end
			var_q = sq_sum / 128'(k * (k - 1));
			if (var_q[127:64] != 0) o.sdev = 31'h7FFFFFFF;
			else begin
				a = isqrt(var_q[63:0]);
				o.sdev = (a > 64'h7FFFFFFF) ? 31'h7FFFFFFF : a[30:0];
			end
		end
		n = 0;
		while (n + 1 < held && n < max_len) begin
			n++;
			df = val_back(0) - val_back(n);
			a = df < 0 ? -df : df;
			if (a >= 64'(thresh)) break;
		end
		o.moves = 5'(n);
		o.fill = 5'(held);
		return o;
	endfunction

	// driver: one request per gap draw
	int gap_left = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_stats.push_back(window_stats(pending_samples.pop_front()));
			gap_left <= $urandom_range(0, 7);
			s_tvalid <= 1'b0;
		end else if (!s_tvalid && arst_n && !pause_req) begin
			if (gap_left > 0) gap_left <= gap_left - 1;
			else if (pending_samples.size() > 0) begin
				s_tdata <= {pending_samples[0].val, pending_samples[0].tm};
				s_tvalid <= 1'b1;
			end
		end
	end

	// monitor with random output stalls
	int stall_left = 0;
	always @(posedge clk) begin
		stats_t e;
		logic [M_TDATA_W-1:0] got;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (got[31:0] !== e.rate) begin
					$display("%0t: rate exp %h got %h", $time, e.rate, got[31:0]);
					errors++;
				end
				if (got[63:32] !== e.mean) begin
					$display("%0t: mean exp %h got %h", $time, e.mean, got[63:32]);
					errors++;
				end
				if (got[94:64] !== e.sdev) begin
					$display("%0t: stddev exp %h got %h", $time, e.sdev, got[94:64]);
					errors++;
				end
				if (got[99:95] !== e.moves) begin
					$display("%0t: moves exp %0d got %0d", $time, e.moves, got[99:95]);
					errors++;
				end
				if (got[104:100] !== e.fill) begin
					$display("%0t: fill exp %0d got %0d", $time, e.fill, got[104:100]);
					errors++;
				end
			end
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= arst_n;
		end
	end

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW_LEN:   win_len = v[4:0];
			REG_MOVE_THRESH:  thresh = v;
			REG_MOVE_MAX_LEN: max_len = v[4:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !s_tvalid);
		wait (expected_stats.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic sample_t rand_sample(int mode, logic [31:0] t_prev, logic [31:0] v_prev);
		sample_t s;
		case (mode)
			0: begin s.tm = $urandom(); s.val = $urandom(); end
			1: begin
				s.tm = t_prev + $urandom_range(0, 3);
				s.val = v_prev + $urandom_range(0, 255) - 128;
			end
			default: begin
				s.tm = t_prev + $urandom_range(1, 1000);
				s.val = v_prev + ($urandom() >> $urandom_range(4, 31))
					- ($urandom() >> $urandom_range(4, 31));
			end
		endcase
		return s;
	endfunction

	task automatic random_phase(int count);
		logic [31:0] t, v;
		sample_t s;
		int mode;
		t = $urandom();
		v = $urandom();
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
			s = rand_sample(mode, t, v);
			t = s.tm;
			v = s.val;
			pending_samples.push_back(s);
		end
		drain();
	endtask

	initial begin
		head_slot = DEPTH - 1;
		held = 0;
		win_len = 16;
		thresh = 0;
		max_len = 16;
		foreach (hist_val[i]) begin
			hist_val[i] = 0;
			hist_tm[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// defaults: extremes, equal times, backward time, large swings
		pending_samples.push_back('{32'd100, 32'h0001_0000});
		pending_samples.push_back('{32'd100, 32'h7FFF_FFFF});
		pending_samples.push_back('{32'd101, 32'h8000_0000});
		pending_samples.push_back('{32'd50, 32'h7FFF_FFFF});
		pending_samples.push_back('{32'hFFFF_FFFF, 32'h8000_0000});
		pending_samples.push_back('{32'd0, 32'h0000_0000});
		pending_samples.push_back('{32'd1, 32'h7FFF_FFFF});
		for (int i = 0; i < 14; i++)
			pending_samples.push_back('{32'(200 + i), 32'(i * 65536)});
		drain();
		// window 0, threshold max, no movement search
		write_reg(REG_WINDOW_LEN, 0);
		write_reg(REG_MOVE_THRESH, 31'h7FFF_FFFF);
		write_reg(REG_MOVE_MAX_LEN, 0);
		pending_samples.push_back('{32'd300, 32'h8000_0000});
		pending_samples.push_back('{32'd301, 32'h7FFF_FFFF});
		drain();
		write_reg(REG_WINDOW_LEN, 1);
		write_reg(REG_MOVE_MAX_LEN, 16);
		random_phase(300);
		write_reg(REG_WINDOW_LEN, 2);
		write_reg(REG_MOVE_THRESH, 31'h100);
		write_reg(REG_MOVE_MAX_LEN, 5);
		random_phase(300);
		// sender holds off until the block has drained
		pause_req = 1'b1;
		random_phase(0);
		pause_req = 1'b0;
		write_reg(REG_WINDOW_LEN, 16);
		write_reg(REG_MOVE_THRESH, 31'h8000);
		write_reg(REG_MOVE_MAX_LEN, 16);
		random_phase(400);
		write_reg(REG_WINDOW_LEN, 9);
		write_reg(REG_MOVE_THRESH, 0);
		write_reg(REG_MOVE_MAX_LEN, 1);
		random_phase(400);
		write_reg(REG_WINDOW_LEN, 15);
		write_reg(REG_MOVE_THRESH, $urandom_range(0, 65535));
		write_reg(REG_MOVE_MAX_LEN, 15);
		random_phase(400);
		if (errors == 0)
			$display("sample_history_window_statistics_core_test passed");
		else
			$display("sample_history_window_statistics_core_test failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("sample_history_window_statistics_core_test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/shws_pkg.sv
rtl/core/shws_cell.sv
rtl/core/shws_div.sv
rtl/core/shws_sqrt.sv
rtl/core/sample_history_window_statistics_core.sv
bench/sample_history_window_statistics_core_test.sv
